/* hdl/dxt_pkg.sv */
`default_nettype none

package dxt_pkg;

  // block_format register codes (code 3 decodes as DXT1)
  localparam logic [1:0] FMT_DXT1 = 2'd0;
  localparam logic [1:0] FMT_DXT3 = 2'd1;
  localparam logic [1:0] FMT_DXT5 = 2'd2;

  // how the back end picks a texel's alpha
  typedef enum logic [1:0] {
    AMODE_COLOR    = 2'd0,
    AMODE_EXPLICIT = 2'd1,
    AMODE_PALETTE  = 2'd2
  } amode_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } rgba_t;

  // one classified block, ready for texel expansion
  typedef struct packed {
    rgba_t [3:0]      cpal;
    logic [31:0]      cidx;
    amode_t           amode;
    logic [7:0][7:0]  apal;
    logic [63:0]      aword;
  } blk_t;

  // one texel result
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    logic [3:0] idx;
    logic       last;
  } texel_t;

  // c*255/31 = 8c + floor(7c/31); 7c/31 via reciprocal 265/2^13
  function automatic logic [7:0] expand5(input logic [4:0] c);
    logic [7:0]  y;
    logic [15:0] p;
    y = {c, 3'b000} - {3'b000, c};
    p = 16'(y) * 16'd265;
    return {c, 3'b000} + {5'b00000, p[15:13]};
  endfunction

  // c*255/63 = 4c + floor(c/21)
  function automatic logic [7:0] expand6(input logic [5:0] c);
    logic [1:0] q;
    if (c >= 6'd63)      q = 2'd3;
    else if (c >= 6'd42) q = 2'd2;
    else if (c >= 6'd21) q = 2'd1;
    else                 q = 2'd0;
    return {c, 2'b00} + {6'b000000, q};
  endfunction

  // x/3 for x <= 765
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] p;
    p = 20'(x) * 20'd683;
    return p[18:11];
  endfunction

  // x/7 for x <= 1785
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [21:0] p;
    p = 22'(x) * 22'd2341;
    return p[21:14];
  endfunction

  // x/5 for x <= 1275
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [20:0] p;
    p = 21'(x) * 21'd1639;
    return p[20:13];
  endfunction

endpackage

`default_nettype wire

/* hdl/dxt_texture_block_decoder_top.sv */
// Channel   Handshake            Payload
// ------    ---------            -------
// block in  start / busy         color_word[63:0], alpha_word[63:0]
// config    cfg_we               cfg_data[1:0] (block_format)
// texel out texel_valid (strobe) red, green, blue, alpha, texel_index, last_texel
//
// One block yields 16 texels, one per cycle; the back end's texel counter
// sets the pace at which new blocks can go in.
// A taken block is classified, queued and emitted, each step registered.
// busy is high while QUEUE_DEPTH blocks are waiting ahead of the back end.
// Reset drops pending blocks and sets the format to DXT1.
// The receiver cannot stall; texels run back to back into a queued next block.
`default_nettype none

module dxt_texture_block_decoder_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] color_word,
  input  wire logic [63:0] alpha_word,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_data,
  output logic             texel_valid,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue,
  output logic [7:0]       alpha,
  output logic [3:0]       texel_index,
  output logic             last_texel
);
  import dxt_pkg::*;

  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

  logic [1:0]       block_format;
  logic [OCC_W-1:0] occ;
  logic             take;
  logic             push;
  blk_t             push_blk;
  logic             pop;
  logic             q_empty;
  blk_t             q_head;
  texel_t           texel;

  // format register
  always_ff @(posedge clk) begin
    if (rst) begin
      block_format <= FMT_DXT1;
    end else if (cfg_we) begin
      block_format <= cfg_data;
    end
  end

  // blocks taken but not yet handed to the back end
  assign take = start && !busy;
  assign busy = (occ == OCC_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ + OCC_W'(take) - OCC_W'(pop);
    end
  end

  dxt_front u_front (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .color_word   (color_word),
    .alpha_word   (alpha_word),
    .block_format (block_format),
    .push         (push),
    .push_blk     (push_blk)
  );

  dxt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_blk (push_blk),
    .pop      (pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  dxt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .pop         (pop),
    .texel_valid (texel_valid),
    .texel       (texel)
  );

  assign red         = texel.r;
  assign green       = texel.g;
  assign blue        = texel.b;
  assign alpha       = texel.a;
  assign texel_index = texel.idx;
  assign last_texel  = texel.last;

endmodule

`default_nettype wire

/* hdl/dxt_front.sv */
`default_nettype none

module dxt_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               take,
  input  wire logic [63:0]        color_word,
  input  wire logic [63:0]        alpha_word,
  input  wire logic [1:0]         block_format,
  output logic                    push,
  output dxt_pkg::blk_t           push_blk
);
  import dxt_pkg::*;

  // first stage: endpoints widened, mode classified, alpha weighted sums
  typedef struct packed {
    logic [2:0][7:0]  e0;        // r,g,b of c0
    logic [2:0][7:0]  e1;        // r,g,b of c1
    logic             three;     // DXT1 three-color plus transparent
    amode_t           amode;
    logic [31:0]      cidx;
    logic [63:0]      aword;
    logic             a_seven;   // a0 > a1
    logic [5:0][10:0] s7;
    logic [3:0][10:0] s5;
  } stage1_t;

  stage1_t    s1;
  stage1_t    s1_next;
  logic       s1_valid;

  logic [15:0] c0;
  logic [15:0] c1;
  logic [7:0]  a0;
  logic [7:0]  a1;
  logic        is_dxt1;

  assign c0 = color_word[15:0];
  assign c1 = color_word[31:16];
  assign a0 = alpha_word[7:0];
  assign a1 = alpha_word[15:8];
  assign is_dxt1 = (block_format != FMT_DXT3) && (block_format != FMT_DXT5);

  // classify and widen
  always_comb begin
    s1_next.e0[2] = expand5(c0[15:11]);
    s1_next.e0[1] = expand6(c0[10:5]);
    s1_next.e0[0] = expand5(c0[4:0]);
    s1_next.e1[2] = expand5(c1[15:11]);
    s1_next.e1[1] = expand6(c1[10:5]);
    s1_next.e1[0] = expand5(c1[4:0]);
    s1_next.three = is_dxt1 && (c0 <= c1);
    unique case (block_format)
      FMT_DXT3: s1_next.amode = AMODE_EXPLICIT;
      FMT_DXT5: s1_next.amode = AMODE_PALETTE;
      default:  s1_next.amode = AMODE_COLOR;
    endcase
    s1_next.cidx    = color_word[63:32];
    s1_next.aword   = alpha_word;
    s1_next.a_seven = (a0 > a1);
    // weights summing to at most 7 on 8-bit values, sums kept at 11 bits
    for (int i = 0; i < 6; i++) begin
      s1_next.s7[i] = ({3'b000, a0} * 11'(6 - i)) + ({3'b000, a1} * 11'(i + 1));
    end
    for (int i = 0; i < 4; i++) begin
      s1_next.s5[i] = ({3'b000, a0} * 11'(4 - i)) + ({3'b000, a1} * 11'(i + 1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take;
    end
    if (take) begin
      s1 <= s1_next;
    end
  end

  // second stage: palettes, written straight into the queue
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      logic [9:0] sum_a;
      logic [9:0] sum_b;
      logic [8:0] mean;
      logic [7:0] p0;
      logic [7:0] p1;
      logic [7:0] p2;
      logic [7:0] p3;
      p0    = s1.e0[ch];
      p1    = s1.e1[ch];
      sum_a = {1'b0, p0, 1'b0} + {2'b00, p1};
      sum_b = {2'b00, p0} + {1'b0, p1, 1'b0};
      mean  = {1'b0, p0} + {1'b0, p1};
      if (s1.three) begin
        p2 = mean[8:1];
        p3 = 8'd0;
      end else begin
        p2 = div3(sum_a);
        p3 = div3(sum_b);
      end
      unique case (ch)
        2: begin
          push_blk.cpal[0].r = p0; push_blk.cpal[1].r = p1;
          push_blk.cpal[2].r = p2; push_blk.cpal[3].r = p3;
        end
        1: begin
          push_blk.cpal[0].g = p0; push_blk.cpal[1].g = p1;
          push_blk.cpal[2].g = p2; push_blk.cpal[3].g = p3;
        end
        default: begin
          push_blk.cpal[0].b = p0; push_blk.cpal[1].b = p1;
          push_blk.cpal[2].b = p2; push_blk.cpal[3].b = p3;
        end
      endcase
    end
    push_blk.cpal[0].a = 8'hff;
    push_blk.cpal[1].a = 8'hff;
    push_blk.cpal[2].a = 8'hff;
    push_blk.cpal[3].a = s1.three ? 8'h00 : 8'hff;

    // alpha palette
    push_blk.apal[0] = s1.aword[7:0];
    push_blk.apal[1] = s1.aword[15:8];
    if (s1.a_seven) begin
      for (int i = 0; i < 6; i++) begin
        push_blk.apal[i + 2] = div7(s1.s7[i]);
      end
    end else begin
      for (int i = 0; i < 4; i++) begin
        push_blk.apal[i + 2] = div5(s1.s5[i]);
      end
      push_blk.apal[6] = 8'h00;
      push_blk.apal[7] = 8'hff;
    end

    push_blk.cidx  = s1.cidx;
    push_blk.amode = s1.amode;
    push_blk.aword = s1.aword;
  end

  assign push = s1_valid;

endmodule

`default_nettype wire

/* hdl/dxt_queue.sv */
`default_nettype none

module dxt_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire dxt_pkg::blk_t  push_blk,
  input  wire logic           pop,
  output logic                empty,
  output dxt_pkg::blk_t       head
);
  import dxt_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  blk_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_blk;
    end
  end

  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

endmodule

`default_nettype wire

/* hdl/dxt_back.sv */
`default_nettype none

module dxt_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_empty,
  input  wire dxt_pkg::blk_t  q_head,
  output logic                pop,
  output logic                texel_valid,
  output dxt_pkg::texel_t     texel
);
  import dxt_pkg::*;

  blk_t       cur;
  logic       active;
  logic [3:0] cnt;
  logic       load;

  logic [1:0]  k;
  rgba_t       sel;
  logic [3:0]  nib;
  logic [47:0] aidx;
  logic [5:0]  aoff;
  logic [2:0]  ak;
  logic [7:0]  alpha_next;

  // take the next block when idle or on the last texel
  assign load = !q_empty && (!active || (cnt == 4'd15));
  assign pop  = load;

  // texel select
  always_comb begin
    k    = cur.cidx[{cnt, 1'b0} +: 2];
    sel  = cur.cpal[k];
    nib  = cur.aword[{cnt, 2'b00} +: 4];
    aidx = cur.aword[63:16];
    aoff = {1'b0, cnt, 1'b0} + {2'b00, cnt};
    ak   = aidx[aoff +: 3];
    unique case (cur.amode)
      AMODE_EXPLICIT: alpha_next = {nib, nib};
      AMODE_PALETTE:  alpha_next = cur.apal[ak];
      default:        alpha_next = sel.a;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      cnt         <= '0;
      texel_valid <= 1'b0;
    end else begin
      texel_valid <= active;
      if (active) cnt <= cnt + 1'b1;
      if (!active || (cnt == 4'd15)) active <= !q_empty;
    end
    if (load) cur <= q_head;
    // result register
    texel.r    <= sel.r;
    texel.g    <= sel.g;
    texel.b    <= sel.b;
    texel.a    <= alpha_next;
    texel.idx  <= cnt;
    texel.last <= (cnt == 4'd15);
  end

endmodule

`default_nettype wire

/* hdl/dxt_checker.sv */
`default_nettype none

module dxt_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       busy,
  input wire logic       texel_valid,
  input wire logic [3:0] texel_index,
  input wire logic       last_texel
);

  // a block's texels come out in one unbroken run
  a_run: assert property (@(posedge clk) disable iff (rst)
    texel_valid && !last_texel |=>
      texel_valid && (texel_index == $past(texel_index) + 4'd1))
    else $error("texel run broken or out of order");

  // last flag marks exactly the sixteenth texel
  a_last: assert property (@(posedge clk) disable iff (rst)
    texel_valid |-> (last_texel == (texel_index == 4'd15)))
    else $error("last_texel does not match texel_index");

  // a run never starts mid-block
  a_first: assert property (@(posedge clk) disable iff (rst)
    texel_valid && (texel_index != 4'd0) |-> $past(texel_valid))
    else $error("texel run started mid-block");

  // reset empties the pipe
  a_reset: assert property (@(posedge clk)
    rst |=> !busy && !texel_valid)
    else $error("busy or strobe right after reset");

endmodule

bind dxt_texture_block_decoder_top dxt_checker u_dxt_checker (
  .clk         (clk),
  .rst         (rst),
  .busy        (busy),
  .texel_valid (texel_valid),
  .texel_index (texel_index),
  .last_texel  (last_texel)
);

`default_nettype wire
